/* src/adx_pkg.sv */
// shared types and constants for the adx adpcm decoder
`default_nettype none

package adx_pkg;

  // stream layout
  localparam int unsigned BLOCK_BYTES       = 18;
  localparam int unsigned SAMPLES_PER_BLOCK = 32;
  localparam int unsigned SCALE_BYTES       = 2;

  // predictor fixed point shift (q13 coefficients)
  localparam int unsigned COEF_SHIFT = 13;

  // field widths
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned HIST_W    = 32;
  localparam int unsigned PROD_W    = 48;
  localparam int unsigned ERR_W     = 21;
  localparam int unsigned TAG_W     = 3;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned BIB_W     = 5;
  localparam int unsigned CHCFG_W   = 4;
  localparam int unsigned PADDR_W   = 4;
  localparam int unsigned PDATA_W   = 32;

  // register index on paddr[3:2]
  typedef enum logic [1:0] {
    REG_COEF_FIRST   = 2'd0,
    REG_COEF_SECOND  = 2'd1,
    REG_CHANNELS     = 2'd2,
    REG_SAMPLE_TOTAL = 2'd3
  } reg_idx_t;

  // control from the sequencer to the predictor unit
  typedef struct packed {
    logic       load;
    logic [3:0] nibble;
  } pred_ctrl_t;

endpackage

`default_nettype wire

/* src/adx_hist_mem.sv */
// per-channel history memory: one write port, one registered read port
`default_nettype none

module adx_hist_mem #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = 3,
  parameter int unsigned DW    = 64
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [DW-1:0]    rd_q;
  logic             rd_valid;

  // storage write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (re) begin
      rd_q <= mem[raddr];
    end
  end

  // written-entry flags; an entry never written reads as zero history
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      if (re) begin
        rd_valid <= valid[raddr];
      end
    end
  end

  assign rdata = rd_valid ? rd_q : '0;

endmodule

`default_nettype wire

/* src/adx_pred.sv */
// predictor unit: registered products, then shift, add and saturate
`default_nettype none

module adx_pred (
  input  wire logic                                clk,
  input  wire adx_pkg::pred_ctrl_t                 ctrl,
  input  wire logic [adx_pkg::SAMPLE_W-1:0]        coef_first,
  input  wire logic [adx_pkg::SAMPLE_W-1:0]        coef_second,
  input  wire logic [adx_pkg::SAMPLE_W-1:0]        scale,
  input  wire logic [adx_pkg::HIST_W-1:0]          hist_recent,
  input  wire logic [adx_pkg::HIST_W-1:0]          hist_older,
  output logic      [adx_pkg::HIST_W-1:0]          sum,
  output logic      [adx_pkg::SAMPLE_W-1:0]        pcm
);

  logic signed [adx_pkg::PROD_W-1:0]  prod_a;
  logic signed [adx_pkg::PROD_W-1:0]  prod_b;
  logic signed [adx_pkg::ERR_W-1:0]   err_q;
  logic signed [adx_pkg::PROD_W:0]    pred_full;
  logic signed [adx_pkg::PROD_W:0]    pred_shr;
  logic        [adx_pkg::HIST_W-1:0]  err_ext;
  logic                               in_range;

  // multiply stage: both predictor taps and the scaled nibble
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      prod_a <= $signed(coef_first) * $signed(hist_recent);
      prod_b <= $signed(coef_second) * $signed(hist_older);
      err_q  <= $signed(ctrl.nibble) * $signed({1'b0, scale});
    end
  end

  // prediction with floor shift, wrapped to 32 bits, plus scaled error
  always_comb begin
    pred_full = {prod_a[adx_pkg::PROD_W-1], prod_a} + {prod_b[adx_pkg::PROD_W-1], prod_b};
    pred_shr  = pred_full >>> adx_pkg::COEF_SHIFT;
    err_ext   = {{(adx_pkg::HIST_W - adx_pkg::ERR_W){err_q[adx_pkg::ERR_W-1]}}, err_q};
    sum       = pred_shr[adx_pkg::HIST_W-1:0] + err_ext;
  end

  // saturate to signed 16 bits
  always_comb begin
    in_range = (sum[adx_pkg::HIST_W-1:adx_pkg::SAMPLE_W-1] == '0) ||
               (sum[adx_pkg::HIST_W-1:adx_pkg::SAMPLE_W-1] == '1);
    if (in_range) begin
      pcm = sum[adx_pkg::SAMPLE_W-1:0];
    end else if (sum[adx_pkg::HIST_W-1]) begin
      pcm = {1'b1, {(adx_pkg::SAMPLE_W-1){1'b0}}};
    end else begin
      pcm = {1'b0, {(adx_pkg::SAMPLE_W-1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

/* src/adx_adpcm_decoder_top.sv */
// top level of the adx adpcm decoder: config port, byte sequencer, output register
`default_nettype none

// Decodes the data area of a 4-bit ADX stream, one byte per input item. Each
// channel block is a big-endian 16-bit scale followed by 16 bytes of nibbles,
// high nibble first; blocks for all channels in use make one frame. Scale bytes
// and bytes whose samples lie at or past stream_sample_total give no result.
// Each kept nibble makes one pass through the shared predictor, a multiply
// state and then a shift-add-saturate state, after the registered history
// memory read; a stalled output holds the sum state. No new byte is taken until
// the last nibble pass of the byte has left its sum state. The two-sample
// history of every channel sits in one memory of MAX_CHANNELS entries, read
// when the byte is taken and written back once after its last kept nibble;
// entries never written read as zero, so no clearing pass follows reset.
// Results carry the channel tag and the per-channel sample number, and
// run_last marks the last result of a byte. Registers (APB, byte addresses):
// 0x0 coef_first, 0x4 coef_second, 0x8 channels_in_use, 0xC stream_sample_total;
// write them only while the decoder is idle.
module adx_adpcm_decoder_top #(
  parameter int unsigned MAX_CHANNELS = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // config port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [adx_pkg::PADDR_W-1:0]       paddr,
  input  wire logic [adx_pkg::PDATA_W-1:0]       pwdata,
  output logic      [adx_pkg::PDATA_W-1:0]       prdata,
  output logic                                   pready,
  // input stream
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [7:0]                        data_byte,
  // output stream
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic      [adx_pkg::SAMPLE_W-1:0]      pcm_sample,
  output logic      [adx_pkg::TAG_W-1:0]         channel_tag,
  output logic      [adx_pkg::CNT_W-1:0]         sample_number,
  output logic                                   run_last
);

  localparam int unsigned CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned MEM_DW = 2 * adx_pkg::HIST_W;
  localparam logic [4:0]  MaxCh  = 5'(MAX_CHANNELS);
  localparam logic [adx_pkg::BIB_W-1:0] LastByte = adx_pkg::BIB_W'(adx_pkg::BLOCK_BYTES - 1);
  localparam logic [adx_pkg::BIB_W-1:0] FirstNib = adx_pkg::BIB_W'(adx_pkg::SCALE_BYTES);
  localparam logic [adx_pkg::CNT_W-1:0] FrameStep =
    adx_pkg::CNT_W'(adx_pkg::SAMPLES_PER_BLOCK);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL0 = 5'b00010,
    S_SUM0 = 5'b00100,
    S_MUL1 = 5'b01000,
    S_SUM1 = 5'b10000
  } state_t;

  // configuration registers
  logic [adx_pkg::SAMPLE_W-1:0] coef_first;
  logic [adx_pkg::SAMPLE_W-1:0] coef_second;
  logic [adx_pkg::CHCFG_W-1:0]  channels_in_use;
  logic [adx_pkg::CNT_W-1:0]    stream_sample_total;

  // stream position
  logic [adx_pkg::BIB_W-1:0]    byte_in_block;
  logic [CH_W-1:0]              block_channel;
  logic [adx_pkg::CNT_W-1:0]    frame_first_sample;
  logic [adx_pkg::SAMPLE_W-1:0] block_scale;

  // per-byte working registers
  state_t                       state;
  state_t                       state_next;
  logic [7:0]                   byte_q;
  logic [CH_W-1:0]              chan_q;
  logic [adx_pkg::CNT_W-1:0]    num_q;
  logic                         keep1;
  logic [adx_pkg::HIST_W-1:0]   work_recent;
  logic [adx_pkg::HIST_W-1:0]   work_older;

  // combinational helpers
  logic                         accept;
  logic                         nib_byte;
  logic [adx_pkg::BIB_W-1:0]    off0;
  logic [adx_pkg::CNT_W:0]      num0_full;
  logic [adx_pkg::CNT_W:0]      num1_full;
  logic                         keep0_c;
  logic                         keep1_c;
  logic [4:0]                   eff_ch;
  logic [4:0]                   ch_inc;
  logic                         cfg_wr;
  logic                         out_free;
  logic                         in_sum;
  logic                         hist_we;
  logic [MEM_DW-1:0]            mem_rdata;
  logic [adx_pkg::HIST_W-1:0]   op_recent;
  logic [adx_pkg::HIST_W-1:0]   op_older;
  logic [adx_pkg::HIST_W-1:0]   pred_sum;
  logic [adx_pkg::SAMPLE_W-1:0] pred_pcm;
  adx_pkg::pred_ctrl_t          pctrl;

  // config port write and read
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_first          <= '0;
      coef_second         <= '0;
      channels_in_use     <= adx_pkg::CHCFG_W'(1);
      stream_sample_total <= '0;
    end else if (cfg_wr) begin
      unique case (adx_pkg::reg_idx_t'(paddr[3:2]))
        adx_pkg::REG_COEF_FIRST:   coef_first          <= pwdata[adx_pkg::SAMPLE_W-1:0];
        adx_pkg::REG_COEF_SECOND:  coef_second         <= pwdata[adx_pkg::SAMPLE_W-1:0];
        adx_pkg::REG_CHANNELS:     channels_in_use     <= pwdata[adx_pkg::CHCFG_W-1:0];
        adx_pkg::REG_SAMPLE_TOTAL: stream_sample_total <= pwdata;
        default:                   coef_first          <= coef_first;
      endcase
    end
  end

  always_comb begin
    unique case (adx_pkg::reg_idx_t'(paddr[3:2]))
      adx_pkg::REG_COEF_FIRST:   prdata = {{(adx_pkg::PDATA_W - adx_pkg::SAMPLE_W){1'b0}},
                                           coef_first};
      adx_pkg::REG_COEF_SECOND:  prdata = {{(adx_pkg::PDATA_W - adx_pkg::SAMPLE_W){1'b0}},
                                           coef_second};
      adx_pkg::REG_CHANNELS:     prdata = {{(adx_pkg::PDATA_W - adx_pkg::CHCFG_W){1'b0}},
                                           channels_in_use};
      adx_pkg::REG_SAMPLE_TOTAL: prdata = stream_sample_total;
      default:                   prdata = '0;
    endcase
  end

  // input acceptance and sample numbering for the byte
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign nib_byte = (byte_in_block >= FirstNib);

  always_comb begin
    off0      = {byte_in_block[3:0] - 4'(adx_pkg::SCALE_BYTES), 1'b0};
    num0_full = {1'b0, frame_first_sample} + (adx_pkg::CNT_W + 1)'(off0);
    num1_full = num0_full + (adx_pkg::CNT_W + 1)'(1);
    keep0_c   = nib_byte && (num0_full < {1'b0, stream_sample_total});
    keep1_c   = nib_byte && (num1_full < {1'b0, stream_sample_total});
  end

  // effective channel count, clamped to 1..MAX_CHANNELS
  always_comb begin
    if (channels_in_use == '0) begin
      eff_ch = 5'd1;
    end else if (5'(channels_in_use) > MaxCh) begin
      eff_ch = MaxCh;
    end else begin
      eff_ch = 5'(channels_in_use);
    end
    ch_inc = 5'(block_channel) + 5'd1;
  end

  // stream position and block scale advance on every accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_in_block      <= '0;
      block_channel      <= '0;
      frame_first_sample <= '0;
      block_scale        <= '0;
    end else if (accept) begin
      if (byte_in_block == '0) begin
        block_scale <= {data_byte, 8'h00};
      end else if (byte_in_block == adx_pkg::BIB_W'(1)) begin
        block_scale <= {block_scale[15:8], data_byte};
      end
      if (byte_in_block == LastByte) begin
        byte_in_block <= '0;
        if (ch_inc >= eff_ch) begin
          block_channel      <= '0;
          frame_first_sample <= frame_first_sample + FrameStep;
        end else begin
          block_channel <= ch_inc[CH_W-1:0];
        end
      end else begin
        byte_in_block <= byte_in_block + adx_pkg::BIB_W'(1);
      end
    end
  end

  // latch the byte's payload for the nibble passes
  always_ff @(posedge clk) begin
    if (accept) begin
      byte_q <= data_byte;
      chan_q <= block_channel;
      num_q  <= num0_full[adx_pkg::CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      keep1 <= 1'b0;
    end else if (accept) begin
      keep1 <= keep1_c;
    end
  end

  // sequencer
  assign out_free = !out_valid || out_ready;
  assign in_sum   = (state == S_SUM0) || (state == S_SUM1);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept && keep0_c) state_next = S_MUL0;
      S_MUL0: state_next = S_SUM0;
      S_SUM0: if (out_free) state_next = keep1 ? S_MUL1 : S_IDLE;
      S_MUL1: state_next = S_SUM1;
      S_SUM1: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // history memory: read on accept, write back after the last kept nibble
  assign hist_we = out_free && ((state == S_SUM1) || ((state == S_SUM0) && !keep1));

  adx_hist_mem #(
    .DEPTH (MAX_CHANNELS),
    .AW    (CH_W),
    .DW    (MEM_DW)
  ) u_hist (
    .clk   (clk),
    .rst   (rst),
    .we    (hist_we),
    .waddr (chan_q),
    .wdata ({pred_sum, work_recent}),
    .re    (accept),
    .raddr (block_channel),
    .rdata (mem_rdata)
  );

  // predictor operands: memory on the first nibble, working history after
  always_comb begin
    if (state == S_MUL0) begin
      op_recent = mem_rdata[MEM_DW-1:adx_pkg::HIST_W];
      op_older  = mem_rdata[adx_pkg::HIST_W-1:0];
    end else begin
      op_recent = work_recent;
      op_older  = work_older;
    end
    pctrl.load   = (state == S_MUL0) || (state == S_MUL1);
    pctrl.nibble = (state == S_MUL0) ? byte_q[7:4] : byte_q[3:0];
  end

  // working history shifts as each nibble completes
  always_ff @(posedge clk) begin
    if (state == S_MUL0) begin
      work_recent <= op_recent;
      work_older  <= op_older;
    end else if (in_sum && out_free) begin
      work_recent <= pred_sum;
      work_older  <= work_recent;
    end
  end

  adx_pred u_pred (
    .clk         (clk),
    .ctrl        (pctrl),
    .coef_first  (coef_first),
    .coef_second (coef_second),
    .scale       (block_scale),
    .hist_recent (op_recent),
    .hist_older  (op_older),
    .sum         (pred_sum),
    .pcm         (pred_pcm)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_sum && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_sum && out_free) begin
      pcm_sample    <= pred_pcm;
      channel_tag   <= adx_pkg::TAG_W'(chan_q);
      sample_number <= (state == S_SUM1) ? num_q + adx_pkg::CNT_W'(1) : num_q;
      run_last      <= (state == S_SUM1) || !keep1;
    end
  end

  // second nibble pass only when that nibble is kept
  a_sum1_kept: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL1) |-> keep1)
    else $error("second nibble pass without a kept second nibble");

  // a new result only comes from a sum cycle
  a_out_from_sum: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_SUM0 || state == S_SUM1))
    else $error("result appeared outside a sum cycle");

  // history write-back returns the sequencer to idle
  a_wb_idle: assert property (@(posedge clk) disable iff (rst)
    hist_we |=> (state == S_IDLE))
    else $error("history written back before the item finished");

  // no item is taken while a nibble pass is in flight
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL0 || state == S_MUL1) |=> !accept)
    else $error("item accepted during a nibble pass");

endmodule

`default_nettype wire

/* sim/tb_adx_adpcm_decoder_top.sv */
// self-checking testbench for the adx adpcm decoder: byte stimulus, apb setup, sample scoreboard
`timescale 1ns / 100ps

typedef struct packed {
  logic [15:0] pcm;
  logic [2:0]  tag;
  logic [31:0] num;
  logic        last;
} pcm_sample_t;

// scoreboard: decodes each accepted byte on its own and checks emitted samples
class pcm_scoreboard;
  int                 max_ch;
  logic signed [15:0] coef_a;
  logic signed [15:0] coef_b;
  logic [3:0]         ch_cfg;
  logic [31:0]        total;
  int                 pos;
  int                 blk_ch;
  logic [31:0]        frame_base;
  logic [15:0]        scale;
  logic signed [31:0] hist_new[8];
  logic signed [31:0] hist_old[8];
  pcm_sample_t        pending_samples[$];
  int                 mismatches;
  int                 bytes_seen;
  int                 samples_seen;
  int                 clipped;
  int                 dropped;

  function new(int max_channels);
    max_ch = max_channels;
    coef_a = '0;
    coef_b = '0;
    ch_cfg = 4'd1;
    total = '0;
    pos = 0;
    blk_ch = 0;
    frame_base = '0;
    scale = '0;
    for (int i = 0; i < 8; i++) begin
      hist_new[i] = '0;
      hist_old[i] = '0;
    end
    mismatches = 0;
    bytes_seen = 0;
    samples_seen = 0;
    clipped = 0;
    dropped = 0;
  endfunction

  function void set_reg(adx_pkg::reg_idx_t idx, logic [31:0] v);
    case (idx)
      adx_pkg::REG_COEF_FIRST:   coef_a = v[15:0];
      adx_pkg::REG_COEF_SECOND:  coef_b = v[15:0];
      adx_pkg::REG_CHANNELS:     ch_cfg = v[3:0];
      adx_pkg::REG_SAMPLE_TOTAL: total = v;
      default: ;
    endcase
  endfunction

  function int pending();
    return pending_samples.size();
  endfunction

  // decode one accepted byte and queue the samples it should give
  function void note_byte(logic [7:0] b);
    int          k;
    int          kept;
    int          n_eff;
    int          err;
    logic [3:0]  nib;
    logic [32:0] num;
    longint      pred;
    longint      s;
    logic [31:0] sum;
    pcm_sample_t pair[2];
    kept = 0;
    bytes_seen++;
    if (pos == 0) begin
      scale = {b, 8'h00};
    end else if (pos == 1) begin
      scale[7:0] = b;
    end else if (pos < adx_pkg::BLOCK_BYTES) begin
      for (k = 0; k < 2; k++) begin
        nib = (k == 0) ? b[7:4] : b[3:0];
        num = {1'b0, frame_base} + 33'((pos - 2) * 2 + k);
        // past the end of the stream: no sample, history untouched
        if (num >= {1'b0, total}) begin
          dropped++;
          continue;
        end
        err = (nib[3] ? int'(nib) - 16 : int'(nib)) * int'(scale);
        pred = longint'(coef_a) * longint'(hist_new[blk_ch]) +
               longint'(coef_b) * longint'(hist_old[blk_ch]);
        pred = pred >>> adx_pkg::COEF_SHIFT;
        sum = 32'(pred) + 32'(err);
        hist_old[blk_ch] = hist_new[blk_ch];
        hist_new[blk_ch] = sum;
        // saturate only the emitted sample
        s = longint'($signed(sum));
        if (s > 32767) begin
          s = 32767;
          clipped++;
        end else if (s < -32768) begin
          s = -32768;
          clipped++;
        end
        pair[kept].pcm = 16'(s);
        pair[kept].tag = 3'(blk_ch);
        pair[kept].num = num[31:0];
        pair[kept].last = 1'b0;
        kept++;
      end
      if (kept > 0) pair[kept - 1].last = 1'b1;
      for (k = 0; k < kept; k++) pending_samples.push_back(pair[k]);
    end
    // advance block and frame position
    pos++;
    if (pos >= adx_pkg::BLOCK_BYTES) begin
      pos = 0;
      blk_ch++;
      n_eff = (ch_cfg == 0) ? 1 : int'(ch_cfg);
      if (n_eff > max_ch) n_eff = max_ch;
      if (blk_ch >= n_eff) begin
        blk_ch = 0;
        frame_base = frame_base + adx_pkg::SAMPLES_PER_BLOCK;
      end
    end
  endfunction

  // compare one emitted sample with the oldest one expected
  function void check_sample(logic [15:0] pcm, logic [2:0] tag, logic [31:0] num, logic last);
    pcm_sample_t want;
    samples_seen++;
    if (pending_samples.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected sample: pcm %0d ch %0d num %0d last %0b",
                 $signed(pcm), tag, num, last);
      return;
    end
    want = pending_samples.pop_front();
    if (want.pcm !== pcm || want.tag !== tag || want.num !== num || want.last !== last) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"sample mismatch: want pcm %0d ch %0d num %0d last %0b, ",
                  "got pcm %0d ch %0d num %0d last %0b"},
                 $signed(want.pcm), want.tag, want.num, want.last,
                 $signed(pcm), tag, num, last);
    end
  endfunction
endclass

module tb_adx_adpcm_decoder_top;

  localparam int MAX_CH      = 8;
  localparam int ITEMS       = 700;
  localparam int SETTLE      = 12;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [adx_pkg::PADDR_W-1:0] paddr = '0;
  logic [adx_pkg::PDATA_W-1:0] pwdata = '0;
  logic [adx_pkg::PDATA_W-1:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [adx_pkg::SAMPLE_W-1:0] pcm_sample;
  logic [adx_pkg::TAG_W-1:0]    channel_tag;
  logic [adx_pkg::CNT_W-1:0]    sample_number;
  logic        run_last;

  pcm_scoreboard sb;
  int          cycles = 0;
  int          sent = 0;
  int          gen_pos = 0;
  int          burst_left = 0;
  int          phase = 0;
  logic [15:0] gen_scale = '0;
  logic [7:0]  stall_cnt = '0;
  int          stall_mode = 0;

  adx_adpcm_decoder_top #(.MAX_CHANNELS(MAX_CH)) u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .data_byte(data_byte),
    .out_valid(out_valid), .out_ready(out_ready), .pcm_sample(pcm_sample),
    .channel_tag(channel_tag), .sample_number(sample_number), .run_last(run_last)
  );

  always #6 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d samples still pending", cycles, sb.pending());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver back-pressure, pattern picked anew whenever stall_cnt[6:0] wraps to zero
  always @(posedge clk) begin
    stall_cnt <= stall_cnt + 1'b1;
    if (stall_cnt[6:0] == 7'd0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= (stall_cnt[1:0] != 2'd3);
      2: out_ready <= ($urandom_range(0, 9) < 4);
      default: out_ready <= (stall_cnt[3:0] > 4'd10);
    endcase
  end

  // monitor both handshakes at the edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_byte(data_byte);
      if (out_valid && out_ready)
        sb.check_sample(pcm_sample, channel_tag, sample_number, run_last);
    end
  end

  // apb write: setup cycle, then access until pready
  task automatic reg_write(input adx_pkg::reg_idx_t idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  // offer one item and wait for it to be taken; bursts with random gaps
  task automatic feed(input logic [7:0] b);
    int gap;
    in_valid <= 1'b1;
    data_byte <= b;
    do @(posedge clk); while (!in_ready);
    sent++;
    gen_pos = (gen_pos + 1) % adx_pkg::BLOCK_BYTES;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // let every pending sample arrive, then let the decoder settle
  task automatic drain();
    in_valid <= 1'b0;
    // the monitor notes the last item at the edge it was taken
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // random byte that fits the position within the block
  function automatic logic [7:0] next_byte();
    if (gen_pos == 0) begin
      case ($urandom_range(0, 7))
        0: gen_scale = 16'hFFFF;
        1: gen_scale = 16'h0000;
        2: gen_scale = 16'h8000;
        3, 4: gen_scale = 16'($urandom_range(1, 16'h0200));
        default: gen_scale = 16'($urandom_range(0, 16'hFFFF));
      endcase
      return gen_scale[15:8];
    end
    if (gen_pos == 1) return gen_scale[7:0];
    case ($urandom_range(0, 7))
      0: return 8'h88;
      1: return 8'h77;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [31:0] pick_coef(input bit first);
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h0000_8000;
          1: return 32'h0000_7FFF;
          2: return 32'h0000_0000;
          default: return 32'h0000_2000;
        endcase
      end
      1, 2: begin
        // weights in the range real streams use
        if (first) return 32'($urandom_range(0, 16'h2000));
        return {16'h0000, 16'(-$urandom_range(0, 16'h1000))};
      end
      default: return 32'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  // per-phase register setup; first phases pin the extremes
  task automatic configure(input int ph);
    int r;
    case (ph)
      0: begin
        reg_write(adx_pkg::REG_CHANNELS, 32'd15);
        reg_write(adx_pkg::REG_COEF_FIRST, 32'h0000_8000);
        reg_write(adx_pkg::REG_COEF_SECOND, 32'h0000_7FFF);
      end
      1: begin
        reg_write(adx_pkg::REG_CHANNELS, 32'd0);
        reg_write(adx_pkg::REG_SAMPLE_TOTAL, sb.frame_base + 32'd5);
      end
      2: begin
        reg_write(adx_pkg::REG_CHANNELS, 32'd1);
        reg_write(adx_pkg::REG_SAMPLE_TOTAL, 32'd0);
      end
      3: begin
        reg_write(adx_pkg::REG_CHANNELS, 32'd8);
        reg_write(adx_pkg::REG_SAMPLE_TOTAL, 32'hFFFF_FFFF);
        reg_write(adx_pkg::REG_COEF_FIRST, 32'h0000_1DAE);
        reg_write(adx_pkg::REG_COEF_SECOND, 32'h0000_F1FF);
      end
      default: begin
        if ($urandom_range(0, 1)) reg_write(adx_pkg::REG_COEF_FIRST, pick_coef(1'b1));
        if ($urandom_range(0, 1)) reg_write(adx_pkg::REG_COEF_SECOND, pick_coef(1'b0));
        if ($urandom_range(0, 1)) begin
          r = $urandom_range(0, 19);
          if (r < 14) reg_write(adx_pkg::REG_CHANNELS, 32'($urandom_range(1, 8)));
          else if (r < 17) reg_write(adx_pkg::REG_CHANNELS, 32'd0);
          else reg_write(adx_pkg::REG_CHANNELS, 32'($urandom_range(9, 15)));
        end
        if ($urandom_range(0, 1)) begin
          r = $urandom_range(0, 19);
          if (r < 10) reg_write(adx_pkg::REG_SAMPLE_TOTAL, 32'hFFFF_FFFF);
          else if (r < 17)
            reg_write(adx_pkg::REG_SAMPLE_TOTAL,
                      sb.frame_base + 32'($urandom_range(0, 96)));
          else if (r < 19) reg_write(adx_pkg::REG_SAMPLE_TOTAL, $urandom);
          else reg_write(adx_pkg::REG_SAMPLE_TOTAL, 32'd0);
        end
      end
    endcase
  endtask

  // main sequence
  initial begin
    logic [7:0] opening[$];
    logic [7:0] first_block[$];
    logic [7:0] second_open[$];
    int len;
    opening = '{8'hFF, 8'hFF, 8'h80, 8'h7F};
    first_block = '{8'h80, 8'h7F, 8'h08, 8'hF7, 8'h00, 8'hFF, 8'h11,
                    8'h99, 8'h77, 8'h88, 8'hF0, 8'h0F, 8'h12, 8'hED};
    second_open = '{8'h00, 8'h01, 8'h7F, 8'h80};
    sb = new(MAX_CH);
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: zero sample total, every nibble dropped
    foreach (opening[i]) feed(opening[i]);
    drain();

    // extreme weights, full scale, two channels
    reg_write(adx_pkg::REG_COEF_FIRST, 32'h0000_7FFF);
    reg_write(adx_pkg::REG_COEF_SECOND, 32'h0000_8000);
    reg_write(adx_pkg::REG_CHANNELS, 32'd2);
    reg_write(adx_pkg::REG_SAMPLE_TOTAL, 32'hFFFF_FFFF);
    foreach (first_block[i]) feed(first_block[i]);
    foreach (second_open[i]) feed(second_open[i]);
    drain();

    // drop the channel count while the second channel's block is open
    reg_write(adx_pkg::REG_CHANNELS, 32'd1);

    // random phases, each with its own register setup
    while (sent < ITEMS) begin
      configure(phase);
      len = $urandom_range(8, 72);
      if (len > ITEMS - sent) len = ITEMS - sent;
      repeat (len) feed(next_byte());
      drain();
      phase++;
    end

    $display("fed %0d bytes over %0d phases, checked %0d samples", sb.bytes_seen,
             phase, sb.samples_seen);
    $display("%0d samples saturated, %0d nibbles past the stream end", sb.clipped,
             sb.dropped);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d samples never seen", sb.mismatches, sb.pending());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/adx_pkg.sv
src/adx_hist_mem.sv
src/adx_pred.sv
src/adx_adpcm_decoder_top.sv
sim/tb_adx_adpcm_decoder_top.sv
